// ===== src/lz2rl_pkg.sv =====
// Shared types, codes and widths for the LZ2 run-length decompressor.
`default_nettype none
package lz2rl_pkg;

    localparam int HISTORY_SIZE_DEF = 65536;
    localparam int ADDR_W           = 16;
    localparam int LEN_W            = 17;
    localparam int RUN_W            = 11;
    localparam int CFG_W            = 17;

    // Configuration register indexes
    localparam logic CFG_OUTPUT_LIMIT = 1'b0;
    localparam logic CFG_SIZE_ONLY    = 1'b1;

    // Request commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // Run kinds taken from the header
    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_FILL    = 3'd1;
    localparam logic [2:0] KIND_ALT     = 3'd2;
    localparam logic [2:0] KIND_INC     = 3'd3;
    localparam logic [2:0] KIND_COPY    = 3'd4;
    localparam logic [2:0] EXT_TAG      = 3'd7;

    localparam logic [7:0] END_MARK = 8'hFF;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_TRUNC    = 2'd2;
    localparam logic [1:0] ERR_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_EXTLEN,
        PH_ARG1,
        PH_ARG2,
        PH_LITERAL,
        PH_RUN
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       source_last;
    } item_t;

    typedef struct packed {
        logic             accepted;
        logic             out_valid;
        logic [7:0]       out_byte;
        logic             run_pending;
        logic             finished;
        logic [LEN_W-1:0] total_length;
        logic [1:0]       error_code;
    } result_t;

    // Outcome of one request plus the history access it needs
    typedef struct packed {
        logic              accepted;
        logic              emit;
        logic              use_hist;
        logic              wr;
        logic [7:0]        byte_val;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              run_pending;
        logic              finished;
        logic [LEN_W-1:0]  total_length;
        logic [1:0]        error_code;
    } step_t;

endpackage
`default_nettype wire

// ===== src/lz2_run_length_decompressor_unit.sv =====
// Top level of the LZ2 run-length decompressor: request intake, history stage, result register.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    item_t   (command, data_byte, source_last)
//  result    out        result_valid / result_stall result_t (one per request)
//  cfg       in         cfg_write                  cfg_index, cfg_data
//
// One request per cycle while item_stall is low; each result passes the history stage, then
// the result register, before it is offered.
// The history memory is read when a request is taken, ahead of its use; a read of the byte
// written by the request just before is forwarded around the memory.
// After reset every history entry is zero-filled while item_stall is held high.
// A stalled result holds in the output register; one more request may sit behind it.
// HISTORY_SIZE must be a power of two.
`default_nettype none
module lz2_run_length_decompressor_unit
    import lz2rl_pkg::*;
#(
    parameter int HISTORY_SIZE = HISTORY_SIZE_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    localparam int HIST_AW = $clog2(HISTORY_SIZE);

    step_t              step;
    logic               take;
    logic               hist_busy;
    logic [7:0]         rd_data;

    logic               s2_valid_reg, s2_valid_next;
    step_t              s2_step_reg;
    logic               s2_fwd_reg;
    logic [7:0]         s2_fwd_data_reg;
    logic               s2_adv;
    logic [7:0]         s2_byte;
    logic               fwd_hit;

    logic               res_valid_reg, res_valid_next;
    result_t            res_reg;

    lz2rl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .step      (step)
    );

    lz2rl_hist #(
        .AW (HIST_AW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take && step.use_hist),
        .rd_addr (step.rd_addr[HIST_AW-1:0]),
        .wr_en   (s2_adv && s2_step_reg.wr),
        .wr_addr (s2_step_reg.wr_addr[HIST_AW-1:0]),
        .wr_data (s2_byte),
        .rd_data (rd_data),
        .busy    (hist_busy)
    );

    assign s2_adv     = s2_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = hist_busy || (s2_valid_reg && !s2_adv);
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        if (!s2_step_reg.emit)
        begin
            s2_byte = 8'd0;
        end
        else if (s2_step_reg.use_hist)
        begin
            s2_byte = s2_fwd_reg ? s2_fwd_data_reg : rd_data;
        end
        else
        begin
            s2_byte = s2_step_reg.byte_val;
        end
    end

    // The write leaving the history stage lands at the same edge as this read
    assign fwd_hit = step.use_hist && s2_adv && s2_step_reg.wr
        && step.rd_addr[HIST_AW-1:0] == s2_step_reg.wr_addr[HIST_AW-1:0];

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (take)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s2_adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_step_reg     <= step;
            s2_fwd_reg      <= fwd_hit;
            s2_fwd_data_reg <= s2_byte;
        end
        if (s2_adv)
        begin
            res_reg.accepted     <= s2_step_reg.accepted;
            res_reg.out_valid    <= s2_step_reg.emit;
            res_reg.out_byte     <= s2_byte;
            res_reg.run_pending  <= s2_step_reg.run_pending;
            res_reg.finished     <= s2_step_reg.finished;
            res_reg.total_length <= s2_step_reg.total_length;
            res_reg.error_code   <= s2_step_reg.error_code;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

// ===== src/lz2rl_hist.sv =====
// History memory with a zero-fill pass after reset.
`default_nettype none
module lz2rl_hist
    import lz2rl_pkg::*;
#(
    parameter int AW = 16
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    output logic [7:0]         rd_data,
    output logic               busy
);

    logic [7:0]    mem [2**AW];
    logic [7:0]    rd_data_reg;
    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 8'd0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule
`default_nettype wire

// ===== src/lz2rl_ctrl.sv =====
// Stream decoder state: header parsing, run bookkeeping, length and errors.
`default_nettype none
module lz2rl_ctrl
    import lz2rl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             take,
    input  wire item_t            item,
    output step_t                 step
);

    phase_t            phase_reg,     phase_next;
    logic [2:0]        kind_reg,      kind_next;
    logic [RUN_W-1:0]  remaining_reg, remaining_next;
    logic [RUN_W-1:0]  position_reg,  position_next;
    logic [7:0]        arg1_reg,      arg1_next;
    logic [7:0]        arg2_reg,      arg2_next;
    logic [ADDR_W-1:0] copy_src_reg,  copy_src_next;
    logic [LEN_W-1:0]  wpos_reg,      wpos_next;
    logic              fin_reg,       fin_next;
    logic [1:0]        err_reg,       err_next;
    logic              counting_reg,  counting_next;
    logic [LEN_W-1:0]  limit_reg;
    logic              size_only_reg;

    logic              do_disp;
    logic              do_start;
    logic              raise_last;
    logic [RUN_W-1:0]  dlen;
    logic [LEN_W:0]    ovf_sum;
    logic [7:0]        b;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [RUN_W-1:0] n);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {{(LEN_W + 1 - RUN_W){1'b0}}, n};
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

    assign b = item.data_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        arg1_next      = arg1_reg;
        arg2_next      = arg2_reg;
        copy_src_next  = copy_src_reg;
        wpos_next      = wpos_reg;
        fin_next       = fin_reg;
        err_next       = err_reg;
        counting_next  = counting_reg;
        step           = '0;
        do_disp        = 1'b0;
        do_start       = 1'b0;
        raise_last     = 1'b0;
        dlen           = '0;
        ovf_sum        = '0;

        if (!fin_reg)
        begin
            if (item.command == CMD_PULL)
            begin
                if (phase_reg == PH_RUN && remaining_reg != '0)
                begin
                    step.accepted = 1'b1;
                    step.emit     = 1'b1;
                    step.wr       = 1'b1;
                    step.wr_addr  = wpos_reg[ADDR_W-1:0];
                    case (kind_reg)
                        KIND_FILL: step.byte_val = arg1_reg;
                        KIND_ALT:  step.byte_val = position_reg[0] ? arg2_reg : arg1_reg;
                        KIND_INC:  step.byte_val = arg1_reg + position_reg[7:0];
                        default:
                        begin
                            step.use_hist = 1'b1;
                            step.rd_addr  = copy_src_reg
                                + {{(ADDR_W - RUN_W){1'b0}}, position_reg};
                        end
                    endcase
                    wpos_next      = sat_add(wpos_reg, RUN_W'(1));
                    position_next  = position_reg + 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                    if (remaining_reg == RUN_W'(1))
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            else if (phase_reg != PH_RUN)
            begin
                step.accepted = 1'b1;
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (b == END_MARK)
                        begin
                            fin_next = 1'b1;
                        end
                        else if (b[7:5] == EXT_TAG)
                        begin
                            if (b[4:2] > KIND_COPY)
                            begin
                                fin_next       = 1'b1;
                                err_next       = ERR_RESERVED;
                                remaining_next = '0;
                            end
                            else
                            begin
                                kind_next      = b[4:2];
                                remaining_next = {{(RUN_W - 2){1'b0}}, b[1:0]};
                                phase_next     = PH_EXTLEN;
                                raise_last     = item.source_last;
                            end
                        end
                        else if (b[7:5] > KIND_COPY)
                        begin
                            fin_next       = 1'b1;
                            err_next       = ERR_RESERVED;
                            remaining_next = '0;
                        end
                        else
                        begin
                            kind_next = b[7:5];
                            do_disp   = 1'b1;
                            dlen      = {{(RUN_W - 5){1'b0}}, b[4:0]} + 1'b1;
                        end
                    end
                    PH_EXTLEN:
                    begin
                        do_disp = 1'b1;
                        dlen    = {1'b0, remaining_reg[1:0], b} + 1'b1;
                    end
                    PH_ARG1:
                    begin
                        arg1_next = b;
                        if (kind_reg == KIND_ALT || kind_reg == KIND_COPY)
                        begin
                            phase_next = PH_ARG2;
                            raise_last = item.source_last;
                        end
                        else
                        begin
                            do_start = 1'b1;
                        end
                    end
                    PH_ARG2:
                    begin
                        arg2_next = b;
                        do_start  = 1'b1;
                    end
                    PH_LITERAL:
                    begin
                        if (!counting_reg)
                        begin
                            step.emit     = 1'b1;
                            step.byte_val = b;
                            step.wr       = 1'b1;
                            step.wr_addr  = wpos_reg[ADDR_W-1:0];
                            wpos_next     = sat_add(wpos_reg, RUN_W'(1));
                        end
                        if (remaining_reg != '0)
                        begin
                            remaining_next = remaining_reg - 1'b1;
                        end
                        if (remaining_next == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                        raise_last = item.source_last;
                    end
                    default:
                    begin
                    end
                endcase

                // Length known: bound check unless only counting, then move to the literal bytes or the operands
                if (do_disp)
                begin
                    counting_next = size_only_reg;
                    ovf_sum = {1'b0, wpos_reg} + {{(LEN_W + 1 - RUN_W){1'b0}}, dlen};
                    if (!size_only_reg && ovf_sum > {1'b0, limit_reg})
                    begin
                        fin_next       = 1'b1;
                        err_next       = ERR_OVERFLOW;
                        remaining_next = '0;
                    end
                    else
                    begin
                        remaining_next = dlen;
                        position_next  = '0;
                        phase_next     = (kind_next == KIND_LITERAL) ? PH_LITERAL : PH_ARG1;
                        if (size_only_reg)
                        begin
                            wpos_next = sat_add(wpos_reg, dlen);
                        end
                        raise_last = item.source_last;
                    end
                end

                // Operands complete: arm the run, or skip it when only counting
                if (do_start)
                begin
                    if (kind_reg == KIND_COPY)
                    begin
                        copy_src_next = {arg1_next, arg2_next};
                    end
                    phase_next = counting_reg ? PH_HEADER : PH_RUN;
                    if (counting_reg)
                    begin
                        remaining_next = '0;
                    end
                    raise_last = item.source_last;
                end

                if (raise_last)
                begin
                    fin_next       = 1'b1;
                    err_next       = ERR_TRUNC;
                    remaining_next = '0;
                end
            end
        end

        step.run_pending  = !fin_next && phase_next == PH_RUN && remaining_next != '0;
        step.finished     = fin_next;
        step.total_length = (fin_next && err_next == ERR_NONE) ? wpos_next : '0;
        step.error_code   = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            kind_reg      <= '0;
            remaining_reg <= '0;
            position_reg  <= '0;
            arg1_reg      <= '0;
            arg2_reg      <= '0;
            copy_src_reg  <= '0;
            wpos_reg      <= '0;
            fin_reg       <= 1'b0;
            err_reg       <= ERR_NONE;
            counting_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            arg1_reg      <= arg1_next;
            arg2_reg      <= arg2_next;
            copy_src_reg  <= copy_src_next;
            wpos_reg      <= wpos_next;
            fin_reg       <= fin_next;
            err_reg       <= err_next;
            counting_reg  <= counting_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LEN_W'(65536);
            size_only_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OUTPUT_LIMIT: limit_reg     <= cfg_data[LEN_W-1:0];
                CFG_SIZE_ONLY:    size_only_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire
